// File: rtl/flhch_pkg.sv
// Package: shared constants and types for the four-layer hit coincidence histogram.
package flhch_pkg;

  localparam int NumChannels = 64;
  localparam int LayerSize   = 16;
  localparam int GridSide    = 31;
  localparam int AdcBits     = 12;
  localparam int CountBits   = 32;

  localparam logic [31:0] FrameMarker = 32'hFFFF_EA0C;
  localparam logic [11:0] ThreshReset = 12'd1000;

  localparam logic [1:0] ModeStream = 2'd0;
  localparam logic [1:0] ModePed    = 2'd1;
  localparam logic [1:0] ModeMap    = 2'd2;
  localparam logic [1:0] ModeRead   = 2'd3;

  // request passed from front to back
  typedef struct packed {
    logic        is_read;    // 1 bin read, 0 frame end
    logic [4:0]  bin_x;
    logic [4:0]  bin_y;
    logic [11:0] event_num;
  } req_t;

endpackage

// File: rtl/four_layer_hit_coincidence_histogram.sv
// Top level: four-layer hit coincidence histogram.
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | mode, data_word, table_*, bin_x/y
//   out     | output    | out_valid/out_stall | result fields
//   config  | input     | APB               | hit_threshold at 0x0
// Stream and table words are accepted whenever in_stall_o is low. A frame end
// runs a 64-sample scan through the sample store read port plus four peak
// reads, then a histogram read-modify-write; a bin read is one histogram read.
// After reset the histogram memory is cleared one bin a cycle, during which
// frame ends and bin reads wait in the queue.
// in_stall rises when the request queue is full, and for samples and pedestal
// writes from a frame end until its scan has read the store.
module four_layer_hit_coincidence_histogram #(
  parameter int NUM_CHANNELS = flhch_pkg::NumChannels,
  parameter int LAYER_SIZE   = flhch_pkg::LayerSize,
  parameter int GRID_SIDE    = flhch_pkg::GridSide,
  parameter int ADC_BITS     = flhch_pkg::AdcBits,
  parameter int COUNT_BITS   = flhch_pkg::CountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] data_word_i,
  input  logic [5:0]  table_index_i,
  input  logic [11:0] table_value_i,
  input  logic [4:0]  bin_x_i,
  input  logic [4:0]  bin_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic        coincident_o,
  output logic [3:0]  layer_pass_mask_o,
  output logic [3:0]  peak_layer1_o,
  output logic [3:0]  peak_layer2_o,
  output logic [3:0]  peak_layer3_o,
  output logic [3:0]  peak_layer4_o,
  output logic [4:0]  vector_x_o,
  output logic [4:0]  vector_y_o,
  output logic [11:0] event_number_o,
  output logic [31:0] bin_count_o
);
  localparam int PW = $clog2(NUM_CHANNELS);

  logic [11:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= flhch_pkg::ThreshReset;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      thr_q <= pwdata[11:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr == 1'b0 ? {20'd0, thr_q} : 32'd0;

  logic            fq_push, fq_full, bq_valid, bq_pop, busy;
  flhch_pkg::req_t fq_data, bq_data;
  logic [PW-1:0]   rd_pos;
  logic [ADC_BITS-1:0] rd_smp, rd_ped;

  flhch_front #(.NUM_CHANNELS(NUM_CHANNELS), .ADC_BITS(ADC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .data_word_i,
    .table_index_i, .table_value_i, .bin_x_i, .bin_y_i,
    .scan_busy_i(busy), .req_valid_o(fq_push), .req_o(fq_data),
    .req_full_i(fq_full), .rd_pos_i(rd_pos), .rd_sample_o(rd_smp), .rd_ped_o(rd_ped)
  );

  flhch_queue u_queue (
    .clk_i, .rst_ni, .push_i(fq_push), .push_data_i(fq_data), .full_o(fq_full),
    .pop_valid_o(bq_valid), .pop_data_o(bq_data), .pop_i(bq_pop)
  );

  flhch_back #(
    .NUM_CHANNELS(NUM_CHANNELS), .LAYER_SIZE(LAYER_SIZE), .GRID_SIDE(GRID_SIDE),
    .ADC_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i, .rst_ni, .thresh_i(thr_q), .req_valid_i(bq_valid), .req_i(bq_data),
    .req_pop_o(bq_pop), .scan_busy_o(busy), .rd_pos_o(rd_pos),
    .rd_sample_i(rd_smp), .rd_ped_i(rd_ped), .out_valid_o, .out_stall_i,
    .result_kind_o, .coincident_o, .layer_pass_mask_o, .peak_layer1_o,
    .peak_layer2_o, .peak_layer3_o, .peak_layer4_o, .vector_x_o, .vector_y_o,
    .event_number_o, .bin_count_o
  );
endmodule

// File: rtl/flhch_front.sv
// Front end: frame parsing, table writes, sample store, request issue.
module flhch_front #(
  parameter int NUM_CHANNELS = flhch_pkg::NumChannels,
  parameter int ADC_BITS     = flhch_pkg::AdcBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        mode_i,
  input  logic [31:0]                       data_word_i,
  input  logic [5:0]                        table_index_i,
  input  logic [11:0]                       table_value_i,
  input  logic [4:0]                        bin_x_i,
  input  logic [4:0]                        bin_y_i,
  // back end busy scanning sample store
  input  logic                              scan_busy_i,
  output logic                              req_valid_o,
  output flhch_pkg::req_t                   req_o,
  input  logic                              req_full_i,
  // sample and pedestal read port for the back end
  input  logic [$clog2(NUM_CHANNELS)-1:0]   rd_pos_i,
  output logic [ADC_BITS-1:0]               rd_sample_o,
  output logic [ADC_BITS-1:0]               rd_ped_o
);
  localparam int PW = $clog2(NUM_CHANNELS);
  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhSkip = 2'd1;
  localparam logic [1:0] PhHdr  = 2'd2;
  localparam logic [1:0] PhSmp  = 2'd3;

  logic [1:0]    phase_q, phase_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic [11:0]   evt_q, evt_d;
  logic [ADC_BITS-1:0] smp_mem [NUM_CHANNELS];
  logic [ADC_BITS-1:0] ped_mem [NUM_CHANNELS];
  logic [PW-1:0] map_q [NUM_CHANNELS];
  logic [PW-1:0] map_rd_q;
  logic [NUM_CHANNELS-1:0] smp_vld_q, ped_vld_q;
  logic          acc, last_smp, map_we, smp_blk;
  logic          held_q;       // frame end queued, its scan not yet started

  // last sample of a frame needs the scan free and queue room
  assign last_smp   = (mode_i == flhch_pkg::ModeStream) && (phase_q == PhSmp)
                      && (cnt_q == (PW+1)'(NUM_CHANNELS-1));
  // samples and pedestals stay put from frame end until the scan has read them
  assign smp_blk    = (mode_i == flhch_pkg::ModeStream && phase_q == PhSmp)
                      || mode_i == flhch_pkg::ModePed;
  assign in_stall_o = req_full_i || (smp_blk && (held_q || scan_busy_i));
  assign acc        = in_valid_i && !in_stall_o;
  assign map_we     = acc && mode_i == flhch_pkg::ModeMap
                      && 32'(table_index_i) < 32'(NUM_CHANNELS)
                      && 32'(table_value_i) < 32'(NUM_CHANNELS);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    evt_d   = evt_q;
    if (acc && mode_i == flhch_pkg::ModeStream) begin
      case (phase_q)
        PhHunt: if (data_word_i == flhch_pkg::FrameMarker) phase_d = PhSkip;
        PhSkip: phase_d = PhHdr;
        PhHdr: begin
          evt_d   = data_word_i[31:20];
          cnt_d   = '0;
          phase_d = PhSmp;
        end
        default: begin
          if (last_smp) begin
            cnt_d   = '0;
            phase_d = PhHunt;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      cnt_q     <= '0;
      evt_q     <= '0;
      smp_vld_q <= '0;
      ped_vld_q <= '0;
      held_q    <= 1'b0;
      map_rd_q  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) map_q[i] <= PW'(i);
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      evt_q   <= evt_d;
      if (acc && last_smp) held_q <= 1'b1;
      else if (scan_busy_i) held_q <= 1'b0;
      if (map_we)
        map_q[table_index_i[PW-1:0]] <= table_value_i[PW-1:0];
      map_rd_q <= (map_we && table_index_i[PW-1:0] == cnt_d[PW-1:0])
                  ? table_value_i[PW-1:0] : map_q[cnt_d[PW-1:0]];
      if (acc && mode_i == flhch_pkg::ModePed && 32'(table_index_i) < 32'(NUM_CHANNELS))
        ped_vld_q[table_index_i[PW-1:0]] <= 1'b1;
      if (acc && mode_i == flhch_pkg::ModeStream && phase_q == PhSmp)
        smp_vld_q[map_rd_q] <= 1'b1;
    end
  end

  logic [ADC_BITS-1:0] smp_rd, ped_rd;
  logic                smp_v, ped_v;
  always_ff @(posedge clk_i) begin
    if (acc && mode_i == flhch_pkg::ModeStream && phase_q == PhSmp)
      smp_mem[map_rd_q] <= data_word_i[ADC_BITS-1:0];
    if (acc && mode_i == flhch_pkg::ModePed && 32'(table_index_i) < 32'(NUM_CHANNELS))
      ped_mem[table_index_i[PW-1:0]] <= table_value_i[ADC_BITS-1:0];
    smp_rd <= smp_mem[rd_pos_i];
    ped_rd <= ped_mem[rd_pos_i];
    smp_v  <= smp_vld_q[rd_pos_i];
    ped_v  <= ped_vld_q[rd_pos_i];
  end
  assign rd_sample_o = smp_v ? smp_rd : '0;
  assign rd_ped_o    = ped_v ? ped_rd : '0;

  assign req_valid_o = acc && (last_smp || mode_i == flhch_pkg::ModeRead);
  always_comb begin
    req_o           = '0;
    req_o.is_read   = (mode_i == flhch_pkg::ModeRead);
    req_o.bin_x     = bin_x_i;
    req_o.bin_y     = bin_y_i;
    req_o.event_num = evt_q;
  end
endmodule

// File: rtl/flhch_queue.sv
// Two-entry request queue between front and back.
module flhch_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  flhch_pkg::req_t push_data_i,
  output logic            full_o,
  output logic            pop_valid_o,
  output flhch_pkg::req_t pop_data_o,
  input  logic            pop_i
);
  flhch_pkg::req_t ent_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      num_q;

  assign full_o      = num_q == 2'd2;
  assign pop_valid_o = num_q != 2'd0;
  assign pop_data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      num_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      num_q <= num_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= push_data_i;
  end
endmodule

// File: rtl/flhch_back.sv
// Back end: layer scan, hit test, histogram update and bin reads.
module flhch_back #(
  parameter int NUM_CHANNELS = flhch_pkg::NumChannels,
  parameter int LAYER_SIZE   = flhch_pkg::LayerSize,
  parameter int GRID_SIDE    = flhch_pkg::GridSide,
  parameter int ADC_BITS     = flhch_pkg::AdcBits,
  parameter int COUNT_BITS   = flhch_pkg::CountBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [11:0]                     thresh_i,
  input  logic                            req_valid_i,
  input  flhch_pkg::req_t                 req_i,
  output logic                            req_pop_o,
  output logic                            scan_busy_o,
  output logic [$clog2(NUM_CHANNELS)-1:0] rd_pos_o,
  input  logic [ADC_BITS-1:0]             rd_sample_i,
  input  logic [ADC_BITS-1:0]             rd_ped_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_kind_o,
  output logic                            coincident_o,
  output logic [3:0]                      layer_pass_mask_o,
  output logic [3:0]                      peak_layer1_o,
  output logic [3:0]                      peak_layer2_o,
  output logic [3:0]                      peak_layer3_o,
  output logic [3:0]                      peak_layer4_o,
  output logic [4:0]                      vector_x_o,
  output logic [4:0]                      vector_y_o,
  output logic [11:0]                     event_number_o,
  output logic [31:0]                     bin_count_o
);
  localparam int PW   = $clog2(NUM_CHANNELS);
  localparam int JW   = $clog2(LAYER_SIZE);
  localparam int GW   = $clog2(GRID_SIDE);
  localparam int NB   = GRID_SIDE * GRID_SIDE;
  localparam int BW   = $clog2(NB);
  localparam int EW   = ADC_BITS + 1;
  localparam int Half = GRID_SIDE / 2;
  localparam int Span = 4 * LAYER_SIZE;
  localparam int SW   = $clog2(Span + 2);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StClr   = 4'd1;
  localparam logic [3:0] StScan  = 4'd2;
  localparam logic [3:0] StPeak  = 4'd3;
  localparam logic [3:0] StPeakW = 4'd4;
  localparam logic [3:0] StDec   = 4'd5;
  localparam logic [3:0] StHRd   = 4'd6;
  localparam logic [3:0] StHWr   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StBRd   = 4'd9;

  logic [3:0]  st_q;
  logic [BW:0] clr_q;
  logic [SW-1:0] sc_q;          // scan address counter
  logic        rv_q;             // read data valid
  logic [1:0]  lay_q;
  logic [JW-1:0] j_q;
  logic signed [EW-1:0] best_q, sec_q;
  logic [JW-1:0] bpos_q, spos_q;
  logic        found_q;
  logic [JW-1:0] peak_q [4];
  logic [3:0]  fnd_q, veto_q;
  logic [3:0]  mask_q;
  logic [ADC_BITS-1:0] praw_q;
  logic [1:0]  pl_q;
  logic [BW-1:0] hadr_q;
  logic        hok_q;
  logic [COUNT_BITS-1:0] hist [NB];
  logic [COUNT_BITS-1:0] hrd_q;
  logic [COUNT_BITS-1:0] hwd_q;
  logic        hwe_q;
  flhch_pkg::req_t cur_q;

  logic        ovld_q;
  logic        ok_q;
  logic [3:0]  rmask_q;
  logic [JW-1:0] rp_q [4];
  logic [4:0]  vx_q, vy_q;
  logic [31:0] bc_q;
  logic        rk_q;
  logic [11:0] ev_q;

  logic signed [EW-1:0] ex;
  logic [JW-1:0] pdist;
  logic signed [GW+1:0] vx, vy;
  logic        out_free, out_ld;

  assign out_free    = !ovld_q || !out_stall_i;
  assign out_ld      = (st_q == StBRd && rv_q && out_free) || (st_q == StOut && out_free);
  // store must hold still from scan start through the peak reads
  assign scan_busy_o = st_q == StScan || st_q == StDec || st_q == StPeak;
  assign ex    = $signed({1'b0, rd_sample_i}) - $signed({1'b0, rd_ped_i});
  assign pdist = bpos_q > spos_q ? bpos_q - spos_q : spos_q - bpos_q;
  assign vx    = $signed((GW+2)'(peak_q[1])) - $signed((GW+2)'(peak_q[3]))
                 + $signed((GW+2)'(Half));
  assign vy    = $signed((GW+2)'(peak_q[2])) - $signed((GW+2)'(peak_q[0]))
                 + $signed((GW+2)'(Half));

  always_comb begin
    rd_pos_o = sc_q[PW-1:0];
    if (st_q == StPeak) rd_pos_o = PW'({pl_q, {JW{1'b0}}} + peak_q[pl_q]);
  end

  assign req_pop_o = st_q == StIdle && req_valid_i;

  always_ff @(posedge clk_i) begin
    if (hwe_q) hist[hadr_q] <= hwd_q;
    hrd_q <= hist[hadr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClr;
      clr_q   <= '0;
      sc_q    <= '0;
      rv_q    <= 1'b0;
      ovld_q  <= 1'b0;
      hwe_q   <= 1'b0;
      lay_q   <= '0;
      j_q     <= '0;
      pl_q    <= '0;
      hadr_q  <= '0;
    end else begin
      hwe_q  <= (st_q == StClr) || (st_q == StHRd && rv_q && hok_q);
      ovld_q <= out_ld || (ovld_q && out_stall_i);
      case (st_q)
        StClr: begin
          hadr_q <= clr_q[BW-1:0];
          hwd_q  <= '0;
          clr_q  <= clr_q + 1'b1;
          if (clr_q == (BW+1)'(NB-1)) st_q <= StIdle;
        end
        StIdle: if (req_valid_i) begin
          cur_q <= req_i;
          if (req_i.is_read) begin
            hok_q  <= req_i.bin_x < 5'(GRID_SIDE) && req_i.bin_y < 5'(GRID_SIDE);
            hadr_q <= BW'(32'(req_i.bin_x) * GRID_SIDE + 32'(req_i.bin_y));
            st_q   <= StBRd;
            rv_q   <= 1'b0;
          end else begin
            sc_q  <= '0;
            rv_q  <= 1'b0;
            lay_q <= '0;
            j_q   <= '0;
            st_q  <= StScan;
          end
        end
        StBRd: begin
          rv_q <= 1'b1;
          if (rv_q && out_free) begin
            rk_q    <= 1'b1;
            ok_q    <= 1'b0;
            rmask_q <= '0;
            for (int k = 0; k < 4; k++) rp_q[k] <= '0;
            vx_q <= '0;
            vy_q <= '0;
            ev_q <= '0;
            bc_q <= hok_q ? 32'(hrd_q) : 32'd0;
            st_q <= StIdle;
          end
        end
        StScan: begin
          if (sc_q < SW'(Span)) sc_q <= sc_q + 1'b1;
          rv_q <= sc_q < SW'(Span);
          if (rv_q) begin
            if (j_q == '0) begin
              if (ex > 0) begin
                best_q <= ex; bpos_q <= '0; sec_q <= '0; spos_q <= '0; found_q <= 1'b1;
              end else begin
                best_q <= '0; bpos_q <= '0; sec_q <= '0; spos_q <= '0; found_q <= 1'b0;
              end
            end else if (ex > best_q) begin
              sec_q <= best_q; spos_q <= bpos_q; best_q <= ex; bpos_q <= j_q;
              found_q <= 1'b1;
            end else if (ex > sec_q) begin
              sec_q <= ex; spos_q <= j_q;
            end
            if (j_q == JW'(LAYER_SIZE-1)) begin
              j_q <= '0;
              st_q <= StDec;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        StDec: begin
          peak_q[lay_q] <= bpos_q;
          fnd_q[lay_q]  <= found_q;
          veto_q[lay_q] <= sec_q > $signed({1'b0, thresh_i}) && pdist > JW'(1);
          lay_q <= lay_q + 1'b1;
          rv_q  <= 1'b0;
          // restart reads at the first position of the next layer
          sc_q  <= SW'(32'(lay_q) * LAYER_SIZE + LAYER_SIZE);
          if (lay_q == 2'd3) begin
            pl_q <= '0;
            st_q <= StPeak;
          end else begin
            st_q <= StScan;
          end
        end
        StPeak: begin
          rv_q <= !rv_q;
          if (rv_q) begin
            mask_q[pl_q] <= fnd_q[pl_q] && !veto_q[pl_q] && rd_sample_i > thresh_i;
            pl_q <= pl_q + 1'b1;
            if (pl_q == 2'd3) st_q <= StPeakW;
          end
        end
        StPeakW: begin
          hok_q  <= mask_q == 4'hF && vx >= 0 && vx < GRID_SIDE
                    && vy >= 0 && vy < GRID_SIDE;
          hadr_q <= BW'(32'(vx) * GRID_SIDE + 32'(vy));
          rv_q   <= 1'b0;
          st_q   <= StHRd;
        end
        StHRd: begin
          rv_q <= 1'b1;
          if (rv_q) begin
            if (hok_q) hwd_q <= (&hrd_q) ? hrd_q : hrd_q + 1'b1;
            st_q <= StOut;
          end
        end
        StOut: if (out_free) begin
          rk_q    <= 1'b0;
          ok_q    <= hok_q;
          rmask_q <= mask_q;
          for (int k = 0; k < 4; k++) rp_q[k] <= peak_q[k];
          vx_q <= hok_q ? 5'(vx) : 5'd0;
          vy_q <= hok_q ? 5'(vy) : 5'd0;
          ev_q <= cur_q.event_num;
          bc_q <= '0;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o       = ovld_q;
  assign result_kind_o     = rk_q;
  assign coincident_o      = ok_q;
  assign layer_pass_mask_o = rmask_q;
  assign peak_layer1_o     = 4'(rp_q[0]);
  assign peak_layer2_o     = 4'(rp_q[1]);
  assign peak_layer3_o     = 4'(rp_q[2]);
  assign peak_layer4_o     = 4'(rp_q[3]);
  assign vector_x_o        = vx_q;
  assign vector_y_o        = vy_q;
  assign event_number_o    = ev_q;
  assign bin_count_o       = bc_q;
endmodule
